// ----- rtl/block_quant_dequantizer_macros.svh -----
// assertion helpers for the dequantizer
`ifndef BLOCK_QUANT_DEQUANTIZER_MACROS_SVH
`define BLOCK_QUANT_DEQUANTIZER_MACROS_SVH

// implication checked on every clock edge outside reset
`define BQD_ASSERT_IMPL(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// property that must hold in the cycle after a condition
`define BQD_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/bqd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bqd_pkg;
    localparam int BLOCK_COUNT_BITS_DEF = 16;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [5:0] LEN_Q4 = 6'd18;
    localparam logic [5:0] LEN_Q8 = 6'd34;
    localparam logic [0:0] REG_FORMAT_MODE = 1'b0;
    localparam logic [0:0] REG_BLOCK_TOTAL = 1'b1;

    // fp16 scale to fp32 split fields: sign, special-case flags, biased exponent, 11-bit mantissa
    typedef struct packed {
        logic        sign;
        logic        is_zero;
        logic        is_inf;
        logic        is_nan;
        logic [7:0]  expo;
        logic [10:0] mant;   // with hidden bit
    } scale_t;

    function automatic scale_t unpack_half(input logic [15:0] h);
        scale_t s;
        logic [4:0] ex;
        logic [9:0] man;
        logic [3:0] lz;
        logic [10:0] sh;
        ex = h[14:10];
        man = h[9:0];
        s.sign = h[15];
        s.is_zero = (ex == 5'd0) && (man == 10'd0);
        s.is_inf = (ex == 5'd31) && (man == 10'd0);
        s.is_nan = (ex == 5'd31) && (man != 10'd0);
        s.expo = {3'd0, ex} + 8'd112;
        s.mant = {1'b1, man};
        if (ex == 5'd0) begin
            lz = 4'd0;
            for (int i = 9; i >= 0; i--) begin
                if (man[i] && lz == 4'd0) begin
                    lz = 4'(10 - i);
                end
            end
            sh = {1'b0, man} << lz;
            s.mant = sh;
            s.expo = 8'd113 - {4'd0, lz};
        end
        return s;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/block_quant_dequantizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// data beats are registered in the input stage, then each result in the output register
// throughput: one byte per cycle in 8-bit mode unless the output stalls; 4-bit bytes give
//   two results through the one-result-per-cycle output port and so enter more slowly
// scale bytes give no result
// reset: synchronous, active-low aresetn clears position, counters and valid flags;
//   format_mode resets to 4-bit and block_total to 1
`include "block_quant_dequantizer_macros.svh"
module block_quant_dequantizer #(
    parameter int BLOCK_COUNT_BITS = bqd_pkg::BLOCK_COUNT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [BLOCK_COUNT_BITS-1:0] cfg_data,  // format_mode in bit 0 or block_total
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // value[31:0], element_index[36:32], pad
    output logic [1:0]       m_tuser,   // block_end, tensor_end
    output logic             m_tlast    // run_last
);
    import bqd_pkg::*;

    localparam int CB = BLOCK_COUNT_BITS;

    // configuration
    logic          fmt_reg;
    logic [CB-1:0] total_reg;
    // stream state
    logic [5:0]    pos_reg;
    logic [15:0]   half_reg;
    logic [CB-1:0] done_reg;
    // input stage: one data byte with its flags
    logic          iv_reg;
    logic [7:0]    ib_reg;
    logic          ifmt_reg;
    logic [4:0]    ik_reg;
    logic          ibend_reg;
    logic          itend_reg;
    logic          ihalf_reg;   // 4-bit: high nibble pending
    scale_t        isc_reg;
    // output register
    logic          ov_reg;
    logic [31:0]   oval_reg;
    logic [4:0]    oidx_reg;
    logic          obend_reg;
    logic          otend_reg;
    logic          olast_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= 1'b0;
            total_reg <= CB'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FORMAT_MODE: fmt_reg <= cfg_data[0];
                REG_BLOCK_TOTAL: total_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // output register free for the next result
    logic out_free;
    logic stage_done;   // input stage hands its last result this cycle
    assign out_free = !ov_reg || m_tready;
    assign stage_done = iv_reg && out_free && (ifmt_reg || ihalf_reg);
    assign s_tready = !iv_reg || stage_done;

    // byte bookkeeping
    logic [5:0]    len;
    logic [5:0]    pos;
    logic [5:0]    k6;
    logic          bend;
    logic [CB-1:0] nxt;
    logic          tend;
    logic          accept;
    assign len = fmt_reg ? LEN_Q8 : LEN_Q4;
    assign pos = (pos_reg >= len) ? 6'd0 : pos_reg;
    assign k6 = pos - 6'd2;
    assign bend = (pos == len - 6'd1);
    assign nxt = done_reg + CB'(1);
    assign tend = (nxt == total_reg);
    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 6'd0;
            done_reg <= '0;
            half_reg <= 16'd0;
        end else if (accept) begin
            if (pos == 6'd0) begin
                half_reg[7:0] <= s_tdata;
                pos_reg <= 6'd1;
            end else if (pos == 6'd1) begin
                half_reg[15:8] <= s_tdata;
                pos_reg <= 6'd2;
            end else if (bend) begin
                pos_reg <= 6'd0;
                done_reg <= tend ? '0 : nxt;
            end else begin
                pos_reg <= pos + 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iv_reg <= 1'b0;
            ihalf_reg <= 1'b0;
        end else begin
            if (accept && pos >= 6'd2) begin
                iv_reg <= 1'b1;
                ihalf_reg <= 1'b0;
            end else if (stage_done) begin
                iv_reg <= 1'b0;
            end else if (iv_reg && out_free) begin
                ihalf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && pos >= 6'd2) begin
            ib_reg <= s_tdata;
            ifmt_reg <= fmt_reg;
            ik_reg <= fmt_reg ? k6[4:0] : {k6[3:0], 1'b0};
            ibend_reg <= bend;
            itend_reg <= bend && tend;
            isc_reg <= unpack_half(half_reg);
        end
    end

    // multiply: |q| up to 128 times an 11-bit mantissa, then normalize
    logic signed [8:0] q;
    logic              qs;
    logic [7:0]        qa;
    logic [18:0]       prod;
    logic [4:0]        msb;
    logic [22:0]       frac;
    logic [7:0]        rexp;
    logic [31:0]       val;
    always_comb begin
        if (ifmt_reg) begin
            q = {ib_reg[7], ib_reg};
        end else if (ihalf_reg) begin
            q = $signed({5'd0, ib_reg[7:4]}) - 9'sd8;
        end else begin
            q = $signed({5'd0, ib_reg[3:0]}) - 9'sd8;
        end
        qs = q[8];
        qa = qs ? 8'(-q) : q[7:0];
        prod = {8'd0, isc_reg.mant} * {11'd0, qa};
        msb = 5'd0;
        for (int i = 0; i < 19; i++) begin
            if (prod[i]) begin
                msb = 5'(i);
            end
        end
        frac = 23'({prod, 23'd0} >> msb);
        rexp = isc_reg.expo + {3'd0, msb} - 8'd10;
        if (isc_reg.is_nan || (isc_reg.is_inf && q == 9'sd0)) begin
            val = CANON_NAN;
        end else if (isc_reg.is_inf) begin
            val = {isc_reg.sign ^ qs, 8'hFF, 23'd0};
        end else if (isc_reg.is_zero || q == 9'sd0) begin
            val = {isc_reg.sign ^ qs, 31'd0};
        end else begin
            val = {isc_reg.sign ^ qs, rexp, frac};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (out_free) begin
            ov_reg <= iv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (iv_reg && out_free) begin
            oval_reg <= val;
            oidx_reg <= ik_reg | {4'd0, ihalf_reg};
            obend_reg <= ibend_reg && (ifmt_reg || ihalf_reg);
            otend_reg <= itend_reg && (ifmt_reg || ihalf_reg);
            olast_reg <= ifmt_reg || ihalf_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata = {3'd0, oidx_reg, oval_reg};
    assign m_tuser = {otend_reg, obend_reg};
    assign m_tlast = olast_reg;

    `BQD_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")
    `BQD_ASSERT_IMPL(a_tend_bend, aclk, aresetn, m_tvalid && m_tuser[1],
        m_tuser[0] && m_tlast, "tensor end without block end")
    `BQD_ASSERT_IMPL(a_bend_last, aclk, aresetn, m_tvalid && m_tuser[0],
        m_tlast, "block end on a non-final result")
    `BQD_ASSERT_IMPL(a_pos_range, aclk, aresetn, 1'b1,
        pos_reg <= LEN_Q8, "byte position out of range")
endmodule
`default_nettype wire

// ----- tb/tb_block_quant_dequantizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_block_quant_dequantizer;
    import bqd_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 6;      // margin after the queue drains, for in-flight work
    localparam int BYTE_TARGET  = 1150;
    localparam int PEND_DEPTH   = 256;

    // one dequantized element as it should leave the block
    typedef struct packed {
        logic [31:0] value;
        logic [4:0]  elem_idx;
        logic        blk_end;
        logic        tns_end;
        logic        run_end;
    } element_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;     // format_mode in bit 0, or block_total
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // data_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;      // value[31:0], element_index[36:32], pad
    logic [1:0]  m_tuser;      // block_end, tensor_end
    logic        m_tlast;      // run_last

    block_quant_dequantizer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // shadow copy of the block's registers and stream state
    logic        fmt_q8;
    logic [15:0] tensor_blocks;
    logic [5:0]  blk_pos;
    logic [15:0] blk_scale;
    logic [15:0] blks_finished;

    // expected elements, oldest at pend_rd
    element_t pending_mem[PEND_DEPTH];
    int       pend_wr;
    int       pend_rd;
    int       mismatches;
    int       bytes_sent;
    int       cycle_count;
    int       burst_left;
    int       stall_kind;

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** block_quant_dequantizer: FAILED **");
            $finish;
        end
    end

    task automatic queue_elem(input element_t el);
        pending_mem[pend_wr % PEND_DEPTH] = el;
        pend_wr++;
    endtask

    // fp16 scale times small signed integer, exact in fp32
    function automatic logic [31:0] scale_product(input logic [15:0] h, input int q);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic        sgn;
        logic [10:0] m;
        int          e;
        int          mag;
        logic [31:0] p;
        int          k;
        logic [7:0]  res_exp;
        logic [31:0] shifted;
        ex  = h[14:10];
        man = h[9:0];
        sgn = h[15] ^ (q < 0);
        if (ex == 5'd31) begin
            if (man != 10'd0 || q == 0) return CANON_NAN;
            return {sgn, 8'hFF, 23'd0};
        end
        if (q == 0 || (ex == 5'd0 && man == 10'd0)) return {sgn, 31'd0};
        if (ex == 5'd0) begin
            // subnormal scale: normalize so the hidden bit is set
            m = {1'b0, man};
            e = 113;
            while (!m[10]) begin
                m = m << 1;
                e--;
            end
        end else begin
            m = {1'b1, man};
            e = ex + 112;
        end
        mag = (q < 0) ? -q : q;
        p = mag * m;
        k = 0;
        for (int i = 0; i < 32; i++) begin
            if (p[i]) k = i;
        end
        res_exp = 8'(e + k - 10);
        shifted = p << (23 - k);
        return {sgn, res_exp, shifted[22:0]};
    endfunction

    // advance the shadow stream state by one accepted byte and queue its elements
    task automatic predict_byte(input logic [7:0] b);
        logic [5:0]  blen;
        logic [5:0]  pos;
        logic [4:0]  k;
        logic        bend;
        logic        tend;
        logic [15:0] next_done;
        element_t    el;
        blen = fmt_q8 ? LEN_Q8 : LEN_Q4;
        pos  = (blk_pos >= blen) ? 6'd0 : blk_pos;
        if (pos == 6'd0) begin
            blk_scale[7:0] = b;
            blk_pos = 6'd1;
        end else if (pos == 6'd1) begin
            blk_scale[15:8] = b;
            blk_pos = 6'd2;
        end else begin
            k = 5'(pos - 6'd2);
            bend = (pos == blen - 6'd1);
            next_done = blks_finished + 16'd1;
            tend = bend && (next_done == tensor_blocks);
            if (bend) begin
                blk_pos = 6'd0;
                blks_finished = tend ? 16'd0 : next_done;
            end else begin
                blk_pos = pos + 6'd1;
            end
            if (fmt_q8) begin
                el = '{scale_product(blk_scale, int'($signed(b))), k, bend, tend, 1'b1};
                queue_elem(el);
            end else begin
                // low nibble first, high nibble closes the beat's run
                el = '{scale_product(blk_scale, int'(b[3:0]) - 8), {k[3:0], 1'b0},
                       1'b0, 1'b0, 1'b0};
                queue_elem(el);
                el = '{scale_product(blk_scale, int'(b[7:4]) - 8), {k[3:0], 1'b1},
                       bend, tend, 1'b1};
                queue_elem(el);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    endtask

    // result checker: every accepted beat is matched to the oldest expectation
    always @(posedge aclk) begin
        element_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pend_wr == pend_rd) begin
                report_mismatch("unexpected beat", m_tdata, '0);
            end else begin
                want = pending_mem[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (m_tdata[31:0] !== want.value)
                    report_mismatch("value", 40'(m_tdata[31:0]), 40'(want.value));
                if (m_tdata[36:32] !== want.elem_idx)
                    report_mismatch("element_index", 40'(m_tdata[36:32]),
                                    40'(want.elem_idx));
                if (m_tuser[0] !== want.blk_end)
                    report_mismatch("block_end", 40'(m_tuser[0]), 40'(want.blk_end));
                if (m_tuser[1] !== want.tns_end)
                    report_mismatch("tensor_end", 40'(m_tuser[1]), 40'(want.tns_end));
                if (m_tlast !== want.run_end)
                    report_mismatch("run_last", 40'(m_tlast), 40'(want.run_end));
            end
        end
    end

    // receiver back-pressure: the stall style is redrawn at random among four kinds
    always @(posedge aclk) begin
        if (cycle_count % 200 == 0) stall_kind <= $urandom_range(0, 3);
        case (stall_kind)
            0: begin
                m_tready <= 1'b1;                               // no stalls
            end
            1: begin
                m_tready <= ($urandom_range(0, 9) < 6);         // light random stalls
            end
            2: begin
                m_tready <= (cycle_count % 7) < 3;              // periodic heavy stall
            end
            default: begin
                m_tready <= ($urandom_range(0, 9) < 2);         // mostly stalled
            end
        endcase
    end

    // send one data beat; the sender runs in bursts with random gaps
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_byte(b);
        bytes_sent++;
    endtask

    // let every queued element drain, then allow in-flight work to settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pend_wr != pend_rd) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_FORMAT_MODE) fmt_q8 = val[0];
        else tensor_blocks = val;
    endtask

    task automatic configure(input logic q8, input logic [15:0] total);
        wait_drained();
        write_reg(REG_FORMAT_MODE, {15'd0, q8});
        write_reg(REG_BLOCK_TOTAL, total);
    endtask

    // one whole block with the given scale and random payload
    task automatic send_block(input logic [15:0] scale);
        int n;
        n = fmt_q8 ? 32 : 16;
        send_byte(scale[7:0]);
        send_byte(scale[15:8]);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [15:0] pick_scale();
        logic [15:0] specials[10];
        specials = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFC01,
                     16'h0001, 16'h83FF, 16'h7BFF, 16'h0400};
        if ($urandom_range(0, 4) == 0) return specials[$urandom_range(0, 9)];
        return 16'($urandom_range(0, 65535));
    endfunction

    // reset defaults: 4-bit blocks, one-block tensors; infinite scale over all nibbles
    task automatic test_q4_infinite_scale();
        logic [7:0] payload[16];
        payload = '{8'h08, 8'h80, 8'h00, 8'hFF, 8'h7F, 8'hF7, 8'h18, 8'h81,
                    8'h88, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h12, 8'hED, 8'h9C};
        send_byte(8'h00);
        send_byte(8'h7C);
        foreach (payload[i]) send_byte(payload[i]);
    endtask

    // 8-bit extremes, then a mode switch in the middle of a block
    task automatic test_q8_midstream_switch();
        configure(1'b1, 16'd2);
        send_byte(8'h01);         // subnormal scale
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'hFF);
        // after these beats pos is past the 4-bit block length, so after the switch the next beat starts a new block
        repeat (20) send_byte(8'($urandom_range(0, 255)));
        configure(1'b0, 16'd2);
        send_block(16'h7E00);     // nan scale
    endtask

    // random blocks across many register settings, with some broken blocks
    task automatic test_random_stream();
        logic        modes[8];
        logic [15:0] totals[8];
        int          ph;
        modes  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        totals = '{16'd1, 16'd3, 16'd2, 16'd1, 16'hFFFF, 16'd0, 16'd5, 16'd4};
        ph = 0;
        while (bytes_sent < BYTE_TARGET) begin
            configure(modes[ph % 8], totals[ph % 8]);
            repeat ($urandom_range(2, 6)) send_block(pick_scale());
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            end
            ph++;
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_FORMAT_MODE;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        stall_kind = 0;
        mismatches = 0;
        bytes_sent = 0;
        burst_left = 0;
        pend_wr    = 0;
        pend_rd    = 0;
        fmt_q8        = 1'b0;
        tensor_blocks = 16'd1;
        blk_pos       = '0;
        blk_scale     = '0;
        blks_finished = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_q4_infinite_scale();
        test_q8_midstream_switch();
        test_random_stream();

        wait_drained();
        if (mismatches == 0) begin
            $display("** block_quant_dequantizer: PASSED **");
        end else begin
            $display("** block_quant_dequantizer: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
